[src/psal_pkg.sv]
// ----------------------------------------------------------------------------
// psal_pkg
// Shared widths, payload structs and unit status type for the polyline
// segment arc length block.
// ----------------------------------------------------------------------------
package psal_pkg;

	localparam int COORD_BITS = 24;
	localparam int ID_W       = 32;
	localparam int LEN_W      = 32;
	// |a - b| of two coordinates fits in COORD_BITS unsigned bits
	localparam int MAG_W      = COORD_BITS;
	localparam int PROD_W     = 2 * MAG_W;
	// radicand kept at an even width for two-bit digit steps
	localparam int SQ_W       = 2 * COORD_BITS + 2;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int CNT_W      = $clog2(ROOT_W + 1);
	localparam int ACC_W      = ((ROOT_W > LEN_W) ? ROOT_W : LEN_W) + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [ID_W-1:0] lane_id;
		coord_t          point_x;
		coord_t          point_y;
		logic            lane_start;
	} psal_in_t;

	typedef struct packed {
		logic [ID_W-1:0]  segment_id;
		logic [ID_W-1:0]  segment_lane;
		logic [LEN_W-1:0] start_length;
		logic [LEN_W-1:0] end_length;
		coord_t           box_min_x;
		coord_t           box_min_y;
		coord_t           box_max_x;
		coord_t           box_max_y;
	} psal_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} psal_unit_sts_t;

endpackage

[src/psal_sqdist.sv]
// ----------------------------------------------------------------------------
// psal_sqdist
// Squared distance dx*dx + dy*dy through one shared subtract/abs stage and
// one shared squaring multiplier; a new request is taken only while idle.
// ----------------------------------------------------------------------------
module psal_sqdist (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  psal_pkg::coord_t        ax,
	input  psal_pkg::coord_t        ay,
	input  psal_pkg::coord_t        bx,
	input  psal_pkg::coord_t        by,
	output psal_pkg::psal_unit_sts_t sts,
	output logic [psal_pkg::SQ_W-1:0] sum
);
	import psal_pkg::*;

	typedef enum logic [1:0] {P_IDLE, P_MUL_X, P_MUL_Y, P_ADD} phase_t;

	phase_t             phase_q;
	logic               done_q;
	logic [MAG_W-1:0]   mag_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  acc_q;
	logic [SQ_W-1:0]    sum_q;

	coord_t              op_a;
	coord_t              op_b;
	logic [COORD_BITS:0] diff;
	logic [COORD_BITS:0] diff_neg;
	logic [MAG_W-1:0]    mag;
	logic [PROD_W-1:0]   square;

	// x operands on the start cycle, y operands after
	assign op_a     = (phase_q == P_IDLE) ? ax : ay;
	assign op_b     = (phase_q == P_IDLE) ? bx : by;
	assign diff     = {op_a[COORD_BITS-1], op_a} - {op_b[COORD_BITS-1], op_b};
	assign diff_neg = -diff;
	assign mag      = diff[COORD_BITS] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
	assign square   = mag_q * mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
			mag_q   <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			sum_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						mag_q   <= mag;
						phase_q <= P_MUL_X;
					end
				end
				P_MUL_X: begin
					prod_q  <= square;
					mag_q   <= mag;
					phase_q <= P_MUL_Y;
				end
				P_MUL_Y: begin
					acc_q   <= prod_q;
					prod_q  <= square;
					phase_q <= P_ADD;
				end
				P_ADD: begin
					sum_q   <= SQ_W'(acc_q) + SQ_W'(prod_q);
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	assign sts.busy = (phase_q != P_IDLE);
	assign sts.done = done_q;
	assign sum      = sum_q;

endmodule

[src/psal_isqrt.sv]
// ----------------------------------------------------------------------------
// psal_isqrt
// Floor integer square root, digit by digit: one result bit per cycle from
// two radicand bits, with a single shared compare/subtract.
// ----------------------------------------------------------------------------
module psal_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [psal_pkg::SQ_W-1:0]   radicand,
	output psal_pkg::psal_unit_sts_t    sts,
	output logic [psal_pkg::ROOT_W-1:0] root
);
	import psal_pkg::*;

	localparam logic [CNT_W-1:0] STEPS = CNT_W'(ROOT_W);

	logic [SQ_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              take;

	// bits dropped from the remainder on the shift are always zero
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cnt_q != '0) begin
				rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
				rem_q  <= take ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], take};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end else if (start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= STEPS;
			end
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

[src/polyline_segment_arc_length.sv]
// ----------------------------------------------------------------------------
// polyline_segment_arc_length
// Builds polyline segments with cumulative arc length and bounding box.
// ----------------------------------------------------------------------------
// Usage:
//   Points come in on in_valid/in_ready/in_data, one request at a time.
//   A lane start point (or the first point after reset) is stored at
//   once and gives no result; such points can be taken every cycle. Any
//   other point gives one segment on out_valid/out_ready/out_data.
//   A segment is built in order by the squared distance unit (one shared
//   multiplier), the digit-serial square root (one bit per cycle, 25 bits
//   at 24-bit coordinates), an accumulate step and the output load, with
//   a start pulse before each of the two units.
//   in_ready is low while a segment is being built; the next request is
//   taken the cycle after the result is loaded, so a segment point is never
//   taken before the last segment's result is loaded.
//   The result sits in an output register; a stalled receiver holds it
//   there while the next point is accepted and processed. A new result
//   waits in its last step until the register is free.
//   cfg_wr_en loads cfg_wr_data as the first id into the segment counter;
//   write only while idle. Reset clears all state and the id to zero.
// ----------------------------------------------------------------------------
module polyline_segment_arc_length (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [psal_pkg::ID_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  psal_pkg::psal_in_t        in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output psal_pkg::psal_out_t       out_data
);
	import psal_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_DIST, ST_ROOT, ST_ACC, ST_EMIT} state_t;

	state_t           state_q;
	logic             have_prev_q;
	coord_t           prev_x_q;
	coord_t           prev_y_q;
	coord_t           cur_x_q;
	coord_t           cur_y_q;
	logic [ID_W-1:0]  lane_q;
	logic [LEN_W-1:0] running_q;
	logic [LEN_W-1:0] end_len_q;
	logic [ID_W-1:0]  next_seg_q;
	logic             dist_go_q;
	logic             root_go_q;
	logic             out_valid_q;
	psal_out_t        out_data_q;

	psal_unit_sts_t    dist_sts;
	psal_unit_sts_t    root_sts;
	logic [SQ_W-1:0]   sq_sum;
	logic [ROOT_W-1:0] seg_len;
	logic [ACC_W-1:0]  acc_sum;
	logic [LEN_W-1:0]  acc_sat;
	logic              accept;
	logic              out_free;

	psal_sqdist u_sqdist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_go_q),
		.ax     (cur_x_q),
		.ay     (cur_y_q),
		.bx     (prev_x_q),
		.by     (prev_y_q),
		.sts    (dist_sts),
		.sum    (sq_sum)
	);

	psal_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_go_q),
		.radicand (sq_sum),
		.sts      (root_sts),
		.root     (seg_len)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign acc_sum = ACC_W'(running_q) + ACC_W'(seg_len);
	assign acc_sat = (|acc_sum[ACC_W-1:LEN_W]) ? '1 : acc_sum[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			lane_q      <= '0;
			running_q   <= '0;
			end_len_q   <= '0;
			next_seg_q  <= '0;
			dist_go_q   <= 1'b0;
			root_go_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			dist_go_q <= 1'b0;
			root_go_q <= 1'b0;
			if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.lane_start || !have_prev_q) begin
							prev_x_q    <= in_data.point_x;
							prev_y_q    <= in_data.point_y;
							running_q   <= '0;
							have_prev_q <= 1'b1;
						end else begin
							cur_x_q   <= in_data.point_x;
							cur_y_q   <= in_data.point_y;
							lane_q    <= in_data.lane_id;
							dist_go_q <= 1'b1;
							state_q   <= ST_DIST;
						end
					end
				end
				ST_DIST: begin
					if (dist_sts.done) begin
						root_go_q <= 1'b1;
						state_q   <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_sts.done)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					end_len_q <= acc_sat;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q              <= 1'b1;
						out_data_q.segment_id    <= next_seg_q;
						out_data_q.segment_lane  <= lane_q;
						out_data_q.start_length  <= running_q;
						out_data_q.end_length    <= end_len_q;
						out_data_q.box_min_x     <= (cur_x_q < prev_x_q) ? cur_x_q : prev_x_q;
						out_data_q.box_min_y     <= (cur_y_q < prev_y_q) ? cur_y_q : prev_y_q;
						out_data_q.box_max_x     <= (cur_x_q > prev_x_q) ? cur_x_q : prev_x_q;
						out_data_q.box_max_y     <= (cur_y_q > prev_y_q) ? cur_y_q : prev_y_q;
						running_q                <= end_len_q;
						next_seg_q               <= next_seg_q + 1'b1;
						prev_x_q                 <= cur_x_q;
						prev_y_q                 <= cur_y_q;
						state_q                  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// config should only land while idle; the block does not enforce it
			if (cfg_wr_en)
				next_seg_q <= cfg_wr_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[src/psal_checker.sv]
// ----------------------------------------------------------------------------
// psal_checker
// Port-level checks for the polyline segment arc length block.
// ----------------------------------------------------------------------------
module psal_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_wr_en,
	input logic [psal_pkg::ID_W-1:0] cfg_wr_data,
	input logic                      in_valid,
	input logic                      in_ready,
	input psal_pkg::psal_in_t        in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input psal_pkg::psal_out_t       out_data
);
	import psal_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a new result is only loaded while no request can be taken
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result loaded while accepting requests");

	// arc length never decreases along a segment
	a_len_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.end_length >= out_data.start_length)
		else $error("end length below start length");

	// bounding box is ordered
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.box_min_x <= out_data.box_max_x) &&
			(out_data.box_min_y <= out_data.box_max_y))
		else $error("bounding box min above max");

endmodule

bind polyline_segment_arc_length psal_checker u_psal_checker (.*);

[dv/psal_segment_checker.sv]
// ----------------------------------------------------------------------------
// psal_segment_checker
// Watches the point, segment and config channels of the polyline segment
// arc length block. It keeps its own copy of the lane state, predicts each
// segment, and compares the segments that come out, field by field, in order.
// ----------------------------------------------------------------------------
module psal_segment_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [psal_pkg::ID_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  psal_pkg::psal_in_t        in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  psal_pkg::psal_out_t       out_data,
	output int                        mismatches,
	output int                        segments_pending
);
	import psal_pkg::*;

	coord_t           last_x;
	coord_t           last_y;
	logic [LEN_W-1:0] arc_total;
	logic [ID_W-1:0]  next_id;
	logic             have_point;
	psal_out_t        segments_due[$];
	psal_out_t        oldest;

	function automatic logic [ROOT_W-1:0] floor_root(input logic [63:0] radicand);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand) begin
				root = trial;
			end
		end
		return root[ROOT_W-1:0];
	endfunction

	// |a - b| at one bit more than a coordinate, zero extended to 64 bits
	function automatic logic [63:0] span(input coord_t a, input coord_t b);
		logic [COORD_BITS:0] diff;
		logic [63:0]         wide;
		diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (diff[COORD_BITS]) begin
			diff = -diff;
		end
		wide = 64'(diff);
		return wide;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("segment %h %s: got %h, want %h",
				oldest.segment_id, name, got, want));
		end
	endtask

	task automatic predict_segment(input psal_in_t p);
		logic [63:0]      ax;
		logic [63:0]      ay;
		logic [LEN_W:0]   sum;
		psal_out_t        seg;
		// lane start, or the very first point: store it, no segment
		if (p.lane_start || !have_point) begin
			last_x     = p.point_x;
			last_y     = p.point_y;
			arc_total  = '0;
			have_point = 1'b1;
		end else begin
			ax  = span(p.point_x, last_x);
			ay  = span(p.point_y, last_y);
			sum = {1'b0, arc_total} + (LEN_W+1)'(floor_root(ax * ax + ay * ay));
			seg.segment_id   = next_id;
			seg.segment_lane = p.lane_id;
			seg.start_length = arc_total;
			arc_total        = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
			seg.end_length   = arc_total;
			seg.box_min_x = ($signed(p.point_x) < $signed(last_x)) ? p.point_x : last_x;
			seg.box_min_y = ($signed(p.point_y) < $signed(last_y)) ? p.point_y : last_y;
			seg.box_max_x = ($signed(p.point_x) > $signed(last_x)) ? p.point_x : last_x;
			seg.box_max_y = ($signed(p.point_y) > $signed(last_y)) ? p.point_y : last_y;
			segments_due.insert(segments_due.size(), seg);
			next_id = next_id + 1'b1;
			last_x  = p.point_x;
			last_y  = p.point_y;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x     = '0;
			last_y     = '0;
			arc_total  = '0;
			next_id    = '0;
			have_point = 1'b0;
			mismatches = 0;
			segments_due.delete();
		end else begin
			// a segment leaving now belongs to an earlier request
			if (out_valid && out_ready) begin
				if (segments_due.size() == 0) begin
					report_mismatch($sformatf("segment %h with none expected",
						out_data.segment_id));
				end else begin
					oldest = segments_due.pop_front();
					check_field("segment_id",   out_data.segment_id,   oldest.segment_id);
					check_field("segment_lane", out_data.segment_lane, oldest.segment_lane);
					check_field("start_length", out_data.start_length, oldest.start_length);
					check_field("end_length",   out_data.end_length,   oldest.end_length);
					check_field("box_min_x",    32'(out_data.box_min_x), 32'(oldest.box_min_x));
					check_field("box_min_y",    32'(out_data.box_min_y), 32'(oldest.box_min_y));
					check_field("box_max_x",    32'(out_data.box_max_x), 32'(oldest.box_max_x));
					check_field("box_max_y",    32'(out_data.box_max_y), 32'(oldest.box_max_y));
				end
			end
			if (cfg_wr_en) begin
				next_id = cfg_wr_data;
			end
			if (in_valid && in_ready) begin
				predict_segment(in_data);
			end
		end
		segments_pending = segments_due.size();
	end

endmodule

[dv/polyline_segment_arc_length_tb.sv]
// ----------------------------------------------------------------------------
// polyline_segment_arc_length_tb
// Drives polyline points into the segment arc length block: a directed set
// of corner cases, a lane long enough to saturate the arc length, and random
// lanes under several first segment ids, with random gaps and output stalls.
// A checker beside the block predicts and compares every segment.
// ----------------------------------------------------------------------------
module polyline_segment_arc_length_tb;
	import psal_pkg::*;

	localparam int     SETTLE_CYCLES = 48;
	localparam coord_t COORD_MAX     = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN     = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef enum int {HOP_NEAR, HOP_ANYWHERE, HOP_EDGE, HOP_SAME} hop_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en;
	logic [ID_W-1:0] cfg_wr_data;
	logic            in_valid;
	logic            in_ready;
	psal_in_t        in_data;
	logic            out_valid;
	logic            out_ready;
	psal_out_t       out_data;
	int              mismatches;
	int              segments_pending;
	logic            calm;
	int              idle_pct;

	polyline_segment_arc_length u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	psal_segment_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.mismatches      (mismatches),
		.segments_pending(segments_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: ready stretches broken by stall bursts
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	function automatic coord_t next_coord(input coord_t base, input hop_t hop);
		logic [31:0] r;
		r = $urandom;
		case (hop)
			HOP_NEAR:     return base + {{(COORD_BITS-12){r[11]}}, r[11:0]};
			HOP_ANYWHERE: return r[COORD_BITS-1:0];
			HOP_EDGE:     return r[31] ? COORD_MAX - r[3:0] : COORD_MIN + r[3:0];
			default:      return base;
		endcase
	endfunction

	task automatic send_point(input logic [ID_W-1:0] lane, input coord_t x,
			input coord_t y, input logic start);
		psal_in_t p;
		p.lane_id    = lane;
		p.point_x    = x;
		p.point_y    = y;
		p.lane_start = start;
		in_data  <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (!calm && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// drain every segment before going on
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (segments_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_first_id(input logic [ID_W-1:0] id);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= id;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic random_lane(input int points);
		logic [ID_W-1:0] lane;
		logic [31:0]     r;
		coord_t          x;
		coord_t          y;
		hop_t            hop;
		lane     = $urandom;
		r        = $urandom;
		x        = r[COORD_BITS-1:0];
		r        = $urandom;
		y        = r[COORD_BITS-1:0];
		idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
		// now and then a lane without its start point runs on from the last
		send_point(lane, x, y, $urandom_range(0, 9) != 0);
		repeat (points) begin
			r   = $urandom_range(0, 19);
			hop = (r < 10) ? HOP_NEAR : (r < 15) ? HOP_ANYWHERE :
				(r < 18) ? HOP_EDGE : HOP_SAME;
			x = next_coord(x, hop);
			y = next_coord(y, hop);
			if ($urandom_range(0, 19) == 0) begin
				lane = $urandom;
			end
			send_point(lane, x, y, $urandom_range(0, 19) == 0);
		end
	endtask

	// corner to corner hops, long enough to saturate the arc length
	task automatic long_lane(input int hops);
		logic [ID_W-1:0] lane;
		logic [31:0]     r;
		lane     = $urandom;
		idle_pct = 15;
		send_point(lane, COORD_MIN, COORD_MIN, 1'b1);
		for (int k = 0; k < hops; k++) begin
			r = $urandom;
			if (k[0]) begin
				send_point(lane, COORD_MIN + r[7:0], COORD_MIN + r[15:8], 1'b0);
			end else begin
				send_point(lane, COORD_MAX - r[7:0], COORD_MAX - r[15:8], 1'b0);
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		calm         = 1'b0;
		idle_pct     = 25;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_first_id('0);

		// first point after reset starts a lane even with the flag low
		send_point('0, '0, '0, 1'b0);
		send_point('0, COORD_MAX, COORD_MAX, 1'b0);
		send_point('0, COORD_MIN, COORD_MIN, 1'b0);
		send_point('0, COORD_MIN, COORD_MIN, 1'b0);
		// lane id changes with no start flag
		send_point('1, COORD_MAX, COORD_MIN, 1'b0);
		send_point('1, COORD_MIN, COORD_MAX, 1'b0);
		send_point(32'd5, 24'sd100, -24'sd100, 1'b1);
		send_point(32'd5, 24'sd356, -24'sd100, 1'b0);
		send_point(32'd5, 24'sd1124, 24'sd924, 1'b0);
		send_point(32'd5, 24'sd1125, 24'sd925, 1'b0);
		send_point(32'd5, 24'sd1126, 24'sd925, 1'b0);
		send_point(32'hA5A5_A5A5, -24'sd1, -24'sd1, 1'b0);
		send_point(32'h5A5A_5A5A, '0, '0, 1'b1);
		send_point(32'h5A5A_5A5A, 24'sd16, 24'sd16, 1'b1);
		send_point(32'h5A5A_5A5A, 24'sd20, '0, 1'b0);
		settle();

		// segment id wraps here
		write_first_id(32'hFFFF_FFFD);
		random_lane(6);
		long_lane(190);
		settle();

		write_first_id($urandom);
		repeat (14) random_lane($urandom_range(2, 14));
		settle();

		write_first_id('1);
		repeat (3) random_lane($urandom_range(2, 14));
		calm = 1'b1;
		repeat (4) random_lane($urandom_range(2, 14));
		settle();

		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
